@@ src/lpg_pkg.sv @@
// Package for the line pixel generator: widths, request codes, controller
// states and the command and status structs between controller and datapath.
// No dependencies.
package lpg_pkg;

  // Coordinate width of the endpoints and of pixel_x
  localparam int COORD_BITS  = 13;
  localparam int SCREEN_BITS = 12;
  localparam int COLOUR_BITS = 24;

  // Derived widths
  localparam int ROW_BITS  = COORD_BITS + 1;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int NUM_BITS  = 2 * COORD_BITS + 2;
  localparam int CNT_BITS  = $clog2(COORD_BITS);
  localparam int ROW_CALC_BITS =
    ((SCREEN_BITS > COORD_BITS) ? SCREEN_BITS : COORD_BITS) + 2;

  // Request codes
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } lpg_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_line;
    logic mul;
    logic div_init;
    logic div_step;
    logic emit;
  } lpg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } lpg_stat_t;

endpackage

@@ src/lpg_ctrl.sv @@
// Controller of the line pixel generator: request handshake, sequencing of
// set-up multiply, serial divide and pixel emission. Depends on lpg_pkg.
module lpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  lpg_pkg::lpg_stat_t stat_i,
  output lpg_pkg::lpg_cmd_t  cmd_o
);

  lpg_pkg::lpg_state_e state_q, state_d;
  logic [lpg_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic accept;
  logic div_last;

  assign in_ready_o = (state_q == lpg_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign div_last   = (cnt_q == lpg_pkg::CNT_BITS'(lpg_pkg::COORD_BITS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpg_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type_i == lpg_pkg::REQ_START) begin
            state_d = lpg_pkg::ST_MUL;
          end else if (stat_i.busy) begin
            state_d = lpg_pkg::ST_DINIT;
          end
        end
      end
      lpg_pkg::ST_MUL:   state_d = lpg_pkg::ST_DINIT;
      lpg_pkg::ST_DINIT: state_d = lpg_pkg::ST_DIV;
      lpg_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = lpg_pkg::ST_EMIT;
        end
      end
      lpg_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = lpg_pkg::ST_IDLE;
        end
      end
      default: state_d = lpg_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      lpg_pkg::ST_IDLE:  cmd_o.load_line = accept & (req_type_i == lpg_pkg::REQ_START);
      lpg_pkg::ST_MUL:   cmd_o.mul = 1'b1;
      lpg_pkg::ST_DINIT: cmd_o.div_init = 1'b1;
      lpg_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      lpg_pkg::ST_EMIT:  cmd_o.emit = stat_i.out_free;
      default:           cmd_o = '0;
    endcase
  end

  // Divide step counter
  always_comb begin
    cnt_d = '0;
    if (state_q == lpg_pkg::ST_DIV) begin
      cnt_d = cnt_q + lpg_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpg_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Counter never runs past the last quotient bit
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpg_pkg::ST_DIV |-> cnt_q <= lpg_pkg::CNT_BITS'(lpg_pkg::COORD_BITS - 1))
    else $error("divide counter out of range");

  // An advance with no line in progress is swallowed without work
  a_idle_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == lpg_pkg::REQ_ADVANCE && !stat_i.busy
    |=> state_q == lpg_pkg::ST_IDLE)
    else $error("idle advance started work");

endmodule

@@ src/lpg_dp.sv @@
// Datapath of the line pixel generator: endpoint ordering, numerator
// accumulator, restoring divider and output register. Depends on lpg_pkg.
module lpg_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [lpg_pkg::SCREEN_BITS-1:0] cfg_wdata_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  x_first_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  y_first_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  x_second_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  y_second_i,
  input  logic        [lpg_pkg::COLOUR_BITS-1:0] colour_i,
  input  lpg_pkg::lpg_cmd_t                      cmd_i,
  output lpg_pkg::lpg_stat_t                     stat_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lpg_pkg::COORD_BITS-1:0]  pixel_x_o,
  output logic signed [lpg_pkg::ROW_BITS-1:0]    pixel_row_o,
  output logic        [lpg_pkg::COLOUR_BITS-1:0] pixel_colour_o,
  output logic                                   last_o
);

  localparam int CW = lpg_pkg::COORD_BITS;
  localparam int DW = lpg_pkg::DIFF_BITS;
  localparam int NW = lpg_pkg::NUM_BITS;
  localparam int RC = lpg_pkg::ROW_CALC_BITS;
  localparam logic [CW-1:0] QMAX = {1'b1, {(CW-1){1'b0}}};

  // Line registers
  logic        [lpg_pkg::SCREEN_BITS-1:0] height_q;
  logic signed [CW-1:0] major_now_q, major_stop_q, minor_begin_q;
  logic        [DW-1:0] den_q;
  logic signed [DW-1:0] dminor_q;
  logic                 x_major_q, busy_q;
  logic        [lpg_pkg::COLOUR_BITS-1:0] colour_q;
  logic signed [NW-1:0] num_q;

  // Divider registers
  logic        [DW-1:0] rem_q;
  logic        [CW-1:0] quo_q;
  logic                 neg_q;

  // Output register
  logic                 out_valid_q;
  logic signed [CW-1:0] pixel_x_q;
  logic signed [lpg_pkg::ROW_BITS-1:0] pixel_row_q;
  logic        [lpg_pkg::COLOUR_BITS-1:0] pixel_colour_q;
  logic                 last_q;

  // Endpoint ordering on a start request
  logic signed [DW-1:0] dx, dy, ax, ay;
  logic                 x_major;
  logic signed [CW-1:0] a1, b1, a2, b2, mb, minb, ms, mins;
  logic                 swap;

  always_comb begin
    dx      = DW'(x_second_i) - DW'(x_first_i);
    dy      = DW'(y_second_i) - DW'(y_first_i);
    ax      = dx[DW-1] ? -dx : dx;
    ay      = dy[DW-1] ? -dy : dy;
    x_major = $unsigned(ax) > $unsigned(ay);
    a1      = x_major ? x_first_i  : y_first_i;
    b1      = x_major ? y_first_i  : x_first_i;
    a2      = x_major ? x_second_i : y_second_i;
    b2      = x_major ? y_second_i : x_second_i;
    swap    = a2 < a1;
    mb      = swap ? a2 : a1;
    minb    = swap ? b2 : b1;
    ms      = swap ? a1 : a2;
    mins    = swap ? b1 : b2;
  end

  // Numerator set-up: minor_begin times span
  logic signed [DW:0]   den_s;
  logic signed [NW-1:0] prod;
  assign den_s = $signed({1'b0, den_q});
  assign prod  = minor_begin_q * den_s;

  // Magnitude of the numerator for the divider
  logic [NW-1:0] num_abs;
  assign num_abs = num_q[NW-1] ? $unsigned(-num_q) : $unsigned(num_q);

  // One restoring divide step
  logic [DW+1:0] trial, den_w, sub;
  logic          ge;
  always_comb begin
    trial = {1'b0, rem_q, quo_q[CW-1]};
    den_w = (DW+2)'(den_q);
    ge    = trial >= den_w;
    sub   = trial - den_w;
  end

  // Pixel from the finished quotient
  logic        [CW:0]   q_ext;
  logic signed [CW:0]   q_s;
  logic signed [CW-1:0] minor, px, py;
  logic signed [RC-1:0] h_ext, row_full;
  logic                 den_zero, fin;

  always_comb begin
    den_zero = (den_q == '0);
    q_ext    = {1'b0, quo_q};
    q_s      = neg_q ? -$signed(q_ext) : $signed(q_ext);
    minor    = den_zero ? minor_begin_q : q_s[CW-1:0];
    px       = x_major_q ? major_now_q : minor;
    py       = x_major_q ? minor : major_now_q;
    h_ext    = $signed({{(RC-lpg_pkg::SCREEN_BITS){1'b0}}, height_q});
    row_full = h_ext - RC'(py);
    fin      = major_now_q >= major_stop_q;
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Control registers: height, busy, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        height_q <= cfg_wdata_i;
      end
      if (cmd_i.emit) begin
        busy_q <= !fin;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Line state and numerator accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      major_now_q   <= mb;
      major_stop_q  <= ms;
      minor_begin_q <= minb;
      den_q         <= $unsigned(DW'(ms) - DW'(mb));
      dminor_q      <= DW'(mins) - DW'(minb);
      x_major_q     <= x_major;
      colour_q      <= colour_i;
    end
    if (cmd_i.mul) begin
      num_q <= prod;
    end else if (cmd_i.emit && !fin) begin
      num_q       <= num_q + NW'(dminor_q);
      major_now_q <= major_now_q + CW'(1);
    end
  end

  // Serial divider: remainder starts with the high bits, the low bits shift in
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= num_abs[CW+DW-1:CW];
      quo_q <= num_abs[CW-1:0];
      neg_q <= num_q[NW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? sub[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[CW-2:0], ge};
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pixel_x_q      <= px;
      pixel_row_q    <= row_full[lpg_pkg::ROW_BITS-1:0];
      pixel_colour_q <= colour_q;
      last_q         <= fin;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = pixel_x_q;
  assign pixel_row_o    = pixel_row_q;
  assign pixel_colour_o = pixel_colour_q;
  assign last_o         = last_q;

  // A pending pixel is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("pixel overwritten before it was taken");

  // Quotient magnitude never exceeds 2**(COORD_BITS-1) when the span is non-zero
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !den_zero |-> quo_q <= QMAX)
    else $error("quotient out of coordinate range");

endmodule

@@ src/line_pixel_generator_unit.sv @@
// Line pixel generator, top level: joins controller and datapath.
// Depends on lpg_pkg, lpg_ctrl and lpg_dp.
//
// Usage: a start request (req_type 0) loads two endpoints and a colour and
// yields the line's first pixel; each advance request (req_type 1) yields
// the next pixel along the major axis, last marking the final one. An
// advance with no line in progress is taken and yields nothing. A start
// drops any line still in progress. screen_height is written through
// cfg_we_i / cfg_wdata_i, by the user only while the block is idle; the
// block itself does not enforce this. Rows are height minus y. One request
// is worked on at a time; the next request is taken only once the current
// one has passed through its steps: for a start the set-up multiply, then
// for both kinds the divider set-up, the serial restoring divider and
// emission.
// A finished pixel sits in the output register; if the receiver stalls the
// next request is still taken and worked on, and held at emission until
// the register frees. Reset empties the output, clears the line state to
// idle and sets screen_height to zero.
module line_pixel_generator_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [lpg_pkg::SCREEN_BITS-1:0] cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   req_type_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  x_first_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  y_first_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  x_second_i,
  input  logic signed [lpg_pkg::COORD_BITS-1:0]  y_second_i,
  input  logic        [lpg_pkg::COLOUR_BITS-1:0] colour_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lpg_pkg::COORD_BITS-1:0]  pixel_x_o,
  output logic signed [lpg_pkg::ROW_BITS-1:0]    pixel_row_o,
  output logic        [lpg_pkg::COLOUR_BITS-1:0] pixel_colour_o,
  output logic                                   last_o
);

  lpg_pkg::lpg_cmd_t  cmd;
  lpg_pkg::lpg_stat_t stat;

  lpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lpg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .x_first_i      (x_first_i),
    .y_first_i      (y_first_i),
    .x_second_i     (x_second_i),
    .y_second_i     (y_second_i),
    .colour_i       (colour_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_row_o    (pixel_row_o),
    .pixel_colour_o (pixel_colour_o),
    .last_o         (last_o)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for line_pixel_generator_unit: directed and random line requests,
// checked pixel by pixel against an in-bench rasteriser. Depends on lpg_pkg.
module tb_top;

  localparam int   COORD_BITS  = lpg_pkg::COORD_BITS;
  localparam int   SCREEN_BITS = lpg_pkg::SCREEN_BITS;
  localparam int   COLOUR_BITS = lpg_pkg::COLOUR_BITS;
  localparam int   ROW_BITS    = lpg_pkg::ROW_BITS;
  localparam logic REQ_START   = lpg_pkg::REQ_START;
  localparam logic REQ_ADVANCE = lpg_pkg::REQ_ADVANCE;

  localparam int COORD_MIN     = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 280;
  localparam int REPORT_MAX    = 50;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_LONG_STALL
  } rx_mode_e;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [ROW_BITS-1:0]   row;
    logic        [COLOUR_BITS-1:0] colour;
    logic                          last;
  } pixel_t;

  // Clock and DUT ports
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  logic        [SCREEN_BITS-1:0] cfg_wdata_i    = '0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic                          req_type_i     = REQ_START;
  logic signed [COORD_BITS-1:0]  x_first_i      = '0;
  logic signed [COORD_BITS-1:0]  y_first_i      = '0;
  logic signed [COORD_BITS-1:0]  x_second_i     = '0;
  logic signed [COORD_BITS-1:0]  y_second_i     = '0;
  logic        [COLOUR_BITS-1:0] colour_i       = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic signed [COORD_BITS-1:0]  pixel_x_o;
  logic signed [ROW_BITS-1:0]    pixel_row_o;
  logic        [COLOUR_BITS-1:0] pixel_colour_o;
  logic                          last_o;

  // Rasteriser state
  int                   line_major_pos;
  int                   line_major_first;
  int                   line_major_last;
  int                   line_minor_first;
  int                   line_minor_last;
  bit                   line_x_major;
  bit                   line_active;
  logic [COLOUR_BITS-1:0] line_colour_q;
  logic [SCREEN_BITS-1:0] height_q;

  pixel_t pending_pixels[$];
  int     error_count   = 0;
  int     pixel_count   = 0;
  int     items_sent    = 0;
  int     quiet_cycles  = 0;
  int     burst_left    = 0;
  bit     sender_no_idle = 1'b0;

  rx_mode_e rx_mode     = RX_ALWAYS;
  int       rx_run_left = 0;
  int       stall_left  = 0;

  line_pixel_generator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .x_first_i      (x_first_i),
    .y_first_i      (y_first_i),
    .x_second_i     (x_second_i),
    .y_second_i     (y_second_i),
    .colour_i       (colour_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_row_o    (pixel_row_o),
    .pixel_colour_o (pixel_colour_o),
    .last_o         (last_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < REPORT_MAX) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Minor coordinate at major value m, exact sum truncated toward zero
  function automatic int minor_for(input int m);
    longint span;
    longint num;
    span = longint'(line_major_last) - longint'(line_major_first);
    if (span <= 0) return line_minor_first;
    num = longint'(line_minor_first) * span
        + (longint'(m) - longint'(line_major_first))
        * (longint'(line_minor_last) - longint'(line_minor_first));
    return int'(num / span);
  endfunction

  // Queue the pixel at the current major position and step along
  task automatic emit_pixel();
    int     m;
    int     n;
    int     px;
    int     py;
    longint row_full;
    pixel_t p;
    m        = line_major_pos;
    n        = minor_for(m);
    px       = line_x_major ? m : n;
    py       = line_x_major ? n : m;
    row_full = longint'(height_q) - longint'(py);
    p.x      = px[COORD_BITS-1:0];
    p.row    = row_full[ROW_BITS-1:0];
    p.colour = line_colour_q;
    p.last   = (m >= line_major_last);
    pending_pixels.push_back(p);
    if (p.last) begin
      line_active = 1'b0;
    end else begin
      line_active    = 1'b1;
      line_major_pos = m + 1;
    end
  endtask

  // Expected pixels for one accepted request
  task automatic rasterise_request(input logic rtype, input int xa, input int ya,
                                   input int xb, input int yb,
                                   input logic [COLOUR_BITS-1:0] col);
    int ax;
    int ay;
    int a1;
    int b1;
    int a2;
    int b2;
    if (rtype == REQ_START) begin
      ax = (xb > xa) ? xb - xa : xa - xb;
      ay = (yb > ya) ? yb - ya : ya - yb;
      line_x_major = (ax > ay);
      if (line_x_major) begin
        a1 = xa; b1 = ya; a2 = xb; b2 = yb;
      end else begin
        a1 = ya; b1 = xa; a2 = yb; b2 = xb;
      end
      if (a2 < a1) begin
        line_major_first = a2; line_minor_first = b2;
        line_major_last  = a1; line_minor_last  = b1;
      end else begin
        line_major_first = a1; line_minor_first = b1;
        line_major_last  = a2; line_minor_last  = b2;
      end
      line_colour_q  = col;
      line_major_pos = line_major_first;
      emit_pixel();
    end else if (line_active) begin
      emit_pixel();
    end
  endtask

  // Drive one request and hold it until taken
  task automatic send_request(input logic rtype, input int xa, input int ya,
                              input int xb, input int yb,
                              input logic [COLOUR_BITS-1:0] col);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= rtype;
    x_first_i  <= xa[COORD_BITS-1:0];
    y_first_i  <= ya[COORD_BITS-1:0];
    x_second_i <= xb[COORD_BITS-1:0];
    y_second_i <= yb[COORD_BITS-1:0];
    colour_i   <= col;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (rtype == REQ_START || line_active) items_sent++;
    rasterise_request(rtype, xa, ya, xb, yb, col);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
  endfunction

  // Move c by exactly d either way, staying inside the coordinate range
  function automatic int step_coord(input int c, input int d);
    int s;
    s = $urandom_range(0, 1) ? -d : d;
    if (c + s > COORD_MAX || c + s < COORD_MIN) s = -s;
    return c + s;
  endfunction

  task automatic send_start(input int xa, input int ya, input int xb, input int yb,
                            input logic [COLOUR_BITS-1:0] col);
    send_request(REQ_START, xa, ya, xb, yb, col);
  endtask

  // Advance payload is ignored by the block, so fill it with noise
  task automatic send_advance();
    send_request(REQ_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 COLOUR_BITS'($urandom));
  endtask

  // Burst pacing for the request side
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 16);
    gap = sender_no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Wait until every expected pixel is out and the block has gone quiet
  task automatic drain_pixels();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_screen_height(input logic [SCREEN_BITS-1:0] h);
    drain_pixels();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= h;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    height_q = h;
  endtask

  // Reset height: idle advances, a short shallow line, zero length at the top corner
  task automatic test_reset_height();
    send_advance();
    send_start(0, 0, 3, 1, 24'hFFFFFF);
    while (line_active) send_advance();
    send_advance();
    send_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'h000000);
  endtask

  // Full-range lines, equal spans, restarts mid-line, reversed steep line
  task automatic test_extreme_lines();
    send_start(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 24'hA5A5A5);
    send_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h5A5A5A);
    send_advance();
    send_advance();
    send_start(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN + 1, 24'hFFFFFF);
    send_advance();
    send_advance();
    send_start(2, 5, -1, -3, 24'h123456);
    while (line_active) send_advance();
  endtask

  // One random line: mostly short well-formed runs, some noise
  task automatic random_line();
    int xa;
    int ya;
    int xb;
    int yb;
    int kind;
    int span;
    int d;
    int steps;
    logic [COLOUR_BITS-1:0] col;
    kind  = $urandom_range(0, 99);
    col   = COLOUR_BITS'($urandom);
    xa    = rand_coord();
    ya    = rand_coord();
    steps = 1 << 30;
    if (kind < 75) begin
      span = ($urandom_range(0, 19) == 0) ? 48 : 10;
      xb = step_coord(xa, $urandom_range(0, span));
      yb = step_coord(ya, $urandom_range(0, span));
      if ($urandom_range(0, 11) == 0) steps = $urandom_range(0, span);
    end else if (kind < 82) begin
      xb = xa;
      yb = ya;
    end else if (kind < 90) begin
      d  = $urandom_range(1, 8);
      xb = step_coord(xa, d);
      yb = step_coord(ya, d);
    end else begin
      // long line, cut short by the next start
      xb    = rand_coord();
      yb    = rand_coord();
      steps = $urandom_range(0, 4);
    end
    send_start(xa, ya, xb, yb, col);
    pace_sender();
    while (line_active && steps > 0) begin
      send_advance();
      pace_sender();
      steps--;
    end
    if (!line_active && $urandom_range(0, 9) == 0) begin
      send_advance();
      pace_sender();
    end
  endtask

  task automatic test_random_phase(input logic [SCREEN_BITS-1:0] h, input bit no_idle);
    int target;
    set_screen_height(h);
    sender_no_idle = no_idle;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_line();
  endtask

  // Receiver ready pattern: runs of always-ready, coin flips and long stalls
  always @(negedge clk_i) begin
    if (rx_run_left == 0) begin
      rx_mode     <= rx_mode_e'($urandom_range(0, 2));
      rx_run_left <= $urandom_range(20, 200);
    end else begin
      rx_run_left <= rx_run_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: begin
        out_ready_i <= 1'b1;
      end
      RX_COIN: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left == 0) begin
          out_ready_i <= 1'b1;
          stall_left  <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : 0;
        end else begin
          out_ready_i <= 1'b0;
          stall_left  <= stall_left - 1;
        end
      end
    endcase
  end

  // Pixel checker
  always @(posedge clk_i) begin : check_pixel
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel with none expected: x %0d row %0d",
                                  pixel_x_o, pixel_row_o));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x_o !== want.x)
          report_mismatch($sformatf("pixel %0d: x %0d, expected %0d",
                                    pixel_count, pixel_x_o, want.x));
        if (pixel_row_o !== want.row)
          report_mismatch($sformatf("pixel %0d: row %0d, expected %0d",
                                    pixel_count, pixel_row_o, want.row));
        if (pixel_colour_o !== want.colour)
          report_mismatch($sformatf("pixel %0d: colour %06h, expected %06h",
                                    pixel_count, pixel_colour_o, want.colour));
        if (last_o !== want.last)
          report_mismatch($sformatf("pixel %0d: last %0b, expected %0b",
                                    pixel_count, last_o, want.last));
      end
      pixel_count++;
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    line_active = 1'b0;
    height_q    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_height();
    set_screen_height(COORD_MAX[SCREEN_BITS-1:0]);
    test_extreme_lines();
    test_random_phase(SCREEN_BITS'($urandom_range(1, 4094)), 1'b0);
    test_random_phase('0, 1'b0);
    test_random_phase({SCREEN_BITS{1'b1}}, 1'b0);
    test_random_phase(SCREEN_BITS'($urandom_range(0, 4095)), 1'b1);
    test_random_phase(SCREEN_BITS'($urandom_range(0, 4095)), 1'b0);
    drain_pixels();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
